>>> src/arbt_pkg.sv
// ----------------------------------------------------------------------------
// arbt_pkg
// Shared types and constants of the adaptive retry backoff table.
// ----------------------------------------------------------------------------
`default_nettype none

package arbt_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 8;
	localparam int CATEGORY_BITS = 8;
	localparam int CAT_FIELD_W   = 8;
	localparam int CAT_W         = (CATEGORY_BITS < CAT_FIELD_W) ? CATEGORY_BITS : CAT_FIELD_W;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// field widths
	localparam int OPC_W     = 2;
	localparam int CHAIN_W   = 64;
	localparam int RETRY_W   = 16;
	localparam int DLY_W     = 31;
	localparam int ALU_W     = DLY_W + 2;
	localparam int CFG_IDX_W = 2;

	// opcodes
	localparam logic [OPC_W-1:0] OP_QUERY   = 2'd0;
	localparam logic [OPC_W-1:0] OP_OBSERVE = 2'd1;
	localparam logic [OPC_W-1:0] OP_CLEAR   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DELAY = 2'd2;

	// register reset values
	localparam logic [DLY_W-1:0] MIN_DELAY_RST     = 31'd100;
	localparam logic [DLY_W-1:0] MAX_DELAY_RST     = 31'd8000;
	localparam logic [DLY_W-1:0] DEFAULT_DELAY_RST = 31'd500;

	typedef struct packed {
		logic [OPC_W-1:0]       opcode;
		logic                   has_category;
		logic [CAT_FIELD_W-1:0] category_id;
		logic [CHAIN_W-1:0]     chain_id;
		logic [RETRY_W-1:0]     retry_num;
	} req_item_t;

	typedef struct packed {
		logic [DLY_W-1:0] delay_ms;
		logic [DLY_W-1:0] base_after;
		logic             base_changed;
	} rsp_item_t;

	typedef struct packed {
		logic [DLY_W-1:0] min_delay;
		logic [DLY_W-1:0] max_delay;
		logic [DLY_W-1:0] default_delay;
	} cfg_t;

	typedef struct packed {
		logic [CAT_W-1:0]   cat;
		logic [CHAIN_W-1:0] chain;
		logic [DLY_W-1:0]   base;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} tbl_rd_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             cin;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             cout;
		logic             zero;
	} alu_rsp_t;

endpackage

`default_nettype wire

>>> src/arbt_ram.sv
// ----------------------------------------------------------------------------
// arbt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module arbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> src/arbt_alu.sv
// ----------------------------------------------------------------------------
// arbt_alu
// Shared add / subtract unit with carry-in; subtract borrow doubles as compare.
// ----------------------------------------------------------------------------
`default_nettype none

module arbt_alu (
	input  wire arbt_pkg::alu_req_t req,
	output      arbt_pkg::alu_rsp_t rsp
);
	import arbt_pkg::*;

	logic [ALU_W:0] ext;

	always_comb begin
		case (req.op)
			ALU_ADD: ext = {1'b0, req.a} + {1'b0, req.b} + {{ALU_W{1'b0}}, req.cin};
			ALU_SUB: ext = {1'b0, req.a} - {1'b0, req.b} - {{ALU_W{1'b0}}, req.cin};
			default: ext = '0;
		endcase
		rsp.res  = ext[ALU_W-1:0];
		// carry for add, borrow (a < b + cin) for subtract
		rsp.cout = ext[ALU_W];
		rsp.zero = (ext[ALU_W-1:0] == '0);
	end

endmodule

`default_nettype wire

>>> src/arbt_seq.sv
// ----------------------------------------------------------------------------
// arbt_seq
// Sequencer: key scan and allocation, then query doubling and observe update
// driven through one shared add / subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module arbt_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire arbt_pkg::cfg_t      cfg,
	input  wire logic                req_valid,
	output      logic                req_ready,
	input  wire arbt_pkg::req_item_t req_item,
	output      logic                res_valid,
	input  wire logic                res_ready,
	output      arbt_pkg::rsp_item_t res_item,
	output      arbt_pkg::tbl_wr_t   tbl_wr,
	output      arbt_pkg::tbl_rd_t   tbl_rd,
	input  wire arbt_pkg::entry_t    tbl_rdata
);
	import arbt_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_SCAN  = 14'b00000000000010,
		S_QRY   = 14'b00000000000100,
		S_TGT0  = 14'b00000000001000,
		S_OCMP  = 14'b00000000010000,
		S_OADD  = 14'b00000000100000,
		S_DIFF  = 14'b00000001000000,
		S_RNB   = 14'b00000010000000,
		S_FGAP  = 14'b00000100000000,
		S_FNB   = 14'b00001000000000,
		S_CLMIN = 14'b00010000000000,
		S_CLMAX = 14'b00100000000000,
		S_CHG   = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} seq_state_t;

	seq_state_t state_q;

	logic [TABLE_ENTRIES-1:0] used_q;
	logic                     issue_q;
	logic                     chk_vld_s1;
	logic                     free_found_q;

	logic [OPC_W-1:0]   op_q;
	logic [CAT_W-1:0]   cat_q;
	logic [CHAIN_W-1:0] chain_q;
	logic [RETRY_W-1:0] retry_q;
	logic [IDX_W-1:0]   scan_q;
	logic [IDX_W-1:0]   chk_idx_s1;
	logic [IDX_W-1:0]   free_idx_q;
	logic [IDX_W-1:0]   slot_q;
	logic [DLY_W-1:0]   base_q;
	logic [ALU_W-1:0]   work_q;
	logic [ALU_W-1:0]   tgt_q;
	logic [ALU_W-1:0]   gap_q;
	logic [RETRY_W-1:0] cnt_q;
	rsp_item_t          res_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic             hit;
	logic             lk_done;
	logic             take_free;
	logic             qry_more;
	logic [IDX_W-1:0] alloc_slot;
	logic [DLY_W-1:0] lk_base;
	logic [ALU_W-1:0] base_x;
	logic [ALU_W-1:0] min_x;
	logic [ALU_W-1:0] max_x;

	arbt_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign base_x = ALU_W'(base_q);
	assign min_x  = ALU_W'(cfg.min_delay);
	assign max_x  = ALU_W'(cfg.max_delay);

	// lookup compare on the entry read in the previous cycle
	assign hit = chk_vld_s1 && used_q[chk_idx_s1] &&
		(tbl_rdata.cat == cat_q) && (tbl_rdata.chain == chain_q);
	assign lk_done    = hit || (chk_vld_s1 && (chk_idx_s1 == LAST_IDX));
	assign alloc_slot = free_found_q ? free_idx_q : '0;
	assign lk_base    = hit ? tbl_rdata.base : cfg.default_delay;
	assign take_free  = issue_q && !used_q[scan_q] && !free_found_q;

	// query keeps doubling while retries remain and d is nonzero and below max
	assign qry_more = (cnt_q != '0) && alu_rsp.cout && (work_q != '0);

	always_comb begin
		alu_req.op  = ALU_SUB;
		alu_req.a   = '0;
		alu_req.b   = '0;
		alu_req.cin = 1'b0;
		case (state_q)
			S_QRY: begin
				alu_req.a = work_q;
				alu_req.b = max_x;
			end
			S_TGT0: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = {base_x[ALU_W-2:0], 1'b0};
				alu_req.b  = base_x;
			end
			S_OCMP: begin
				alu_req.a = max_x;
				alu_req.b = work_q;
			end
			S_OADD: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = {work_q[ALU_W-2:0], 1'b0};
				alu_req.b  = base_x;
			end
			S_DIFF: begin
				alu_req.a = tgt_q;
				alu_req.b = base_x;
			end
			S_RNB: begin
				alu_req.op  = ALU_ADD;
				alu_req.a   = base_x;
				alu_req.b   = gap_q >> 1;
				alu_req.cin = gap_q[0];
			end
			S_FGAP: begin
				alu_req.a = base_x;
				alu_req.b = tgt_q;
			end
			S_FNB: begin
				alu_req.a   = base_x;
				alu_req.b   = gap_q >> 3;
				alu_req.cin = |gap_q[2:0];
			end
			S_CLMIN: begin
				alu_req.a = work_q;
				alu_req.b = min_x;
			end
			S_CLMAX: begin
				alu_req.a = max_x;
				alu_req.b = work_q;
			end
			S_CHG: begin
				alu_req.a = work_q;
				alu_req.b = base_x;
			end
			default: begin
				alu_req.op = ALU_SUB;
			end
		endcase
	end

	// table port: allocate on a miss, write back a changed base
	always_comb begin
		tbl_wr.en         = 1'b0;
		tbl_wr.addr       = alloc_slot;
		tbl_wr.data.cat   = cat_q;
		tbl_wr.data.chain = chain_q;
		tbl_wr.data.base  = cfg.default_delay;
		if (state_q == S_SCAN) begin
			tbl_wr.en = lk_done && !hit;
		end else if (state_q == S_CHG) begin
			tbl_wr.en        = !alu_rsp.zero;
			tbl_wr.addr      = slot_q;
			tbl_wr.data.base = work_q[DLY_W-1:0];
		end
	end

	assign tbl_rd.en   = (state_q == S_SCAN) && issue_q;
	assign tbl_rd.addr = scan_q;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_item  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			issue_q      <= 1'b0;
			chk_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						case (req_item.opcode)
							OP_QUERY, OP_OBSERVE: begin
								if (req_item.has_category) begin
									issue_q      <= 1'b1;
									chk_vld_s1   <= 1'b0;
									free_found_q <= 1'b0;
									state_q      <= S_SCAN;
								end else begin
									state_q <= S_DONE;
								end
							end
							OP_CLEAR: begin
								used_q  <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (take_free) begin
						free_found_q <= 1'b1;
					end
					if (issue_q && (scan_q == LAST_IDX)) begin
						issue_q <= 1'b0;
					end
					chk_vld_s1 <= issue_q;
					if (lk_done) begin
						if (!hit) begin
							used_q[alloc_slot] <= 1'b1;
						end
						issue_q    <= 1'b0;
						chk_vld_s1 <= 1'b0;
						if (op_q == OP_QUERY) begin
							state_q <= S_QRY;
						end else if (retry_q == '0) begin
							state_q <= S_TGT0;
						end else begin
							state_q <= S_OCMP;
						end
					end
				end
				S_QRY: begin
					if (!qry_more) begin
						state_q <= S_DONE;
					end
				end
				S_TGT0: begin
					state_q <= S_DIFF;
				end
				S_OCMP: begin
					if (alu_rsp.cout || (cnt_q == '0) || (base_q == '0)) begin
						state_q <= S_DIFF;
					end else begin
						state_q <= S_OADD;
					end
				end
				S_OADD: begin
					state_q <= S_OCMP;
				end
				S_DIFF: begin
					if (alu_rsp.zero) begin
						state_q <= S_CLMIN;
					end else if (alu_rsp.cout) begin
						state_q <= S_FGAP;
					end else begin
						state_q <= S_RNB;
					end
				end
				S_RNB: begin
					state_q <= S_CLMIN;
				end
				S_FGAP: begin
					state_q <= S_FNB;
				end
				S_FNB: begin
					state_q <= S_CLMIN;
				end
				S_CLMIN: begin
					// below min goes straight to min, which wins over max
					state_q <= alu_rsp.cout ? S_CHG : S_CLMAX;
				end
				S_CLMAX: begin
					state_q <= S_CHG;
				end
				S_CHG: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_q    <= req_item.opcode;
					cat_q   <= req_item.category_id[CAT_W-1:0];
					chain_q <= req_item.chain_id;
					retry_q <= req_item.retry_num;
					scan_q  <= '0;
					res_q.base_after   <= '0;
					res_q.base_changed <= 1'b0;
					if ((req_item.opcode == OP_QUERY) && !req_item.has_category) begin
						res_q.delay_ms <= cfg.default_delay;
					end else begin
						res_q.delay_ms <= '0;
					end
				end
			end
			S_SCAN: begin
				if (take_free) begin
					free_idx_q <= scan_q;
				end
				if (issue_q && (scan_q != LAST_IDX)) begin
					scan_q <= scan_q + 1'b1;
				end
				chk_idx_s1 <= scan_q;
				if (lk_done) begin
					slot_q <= hit ? chk_idx_s1 : alloc_slot;
					base_q <= lk_base;
					work_q <= ALU_W'(lk_base);
					cnt_q  <= (op_q == OP_QUERY) ? retry_q : retry_q - 1'b1;
				end
			end
			S_QRY: begin
				if (qry_more) begin
					work_q <= {work_q[ALU_W-2:0], 1'b0};
					cnt_q  <= cnt_q - 1'b1;
				end else begin
					res_q.delay_ms   <= alu_rsp.cout ? work_q[DLY_W-1:0] : cfg.max_delay;
					res_q.base_after <= base_q;
				end
			end
			S_TGT0: begin
				tgt_q <= alu_rsp.res >> 2;
			end
			S_OCMP: begin
				tgt_q <= alu_rsp.cout ? max_x : work_q;
			end
			S_OADD: begin
				work_q <= alu_rsp.res;
				cnt_q  <= cnt_q - 1'b1;
			end
			S_DIFF: begin
				gap_q <= alu_rsp.res;
				if (alu_rsp.zero) begin
					work_q <= base_x;
				end
			end
			S_RNB: begin
				work_q <= alu_rsp.res;
			end
			S_FGAP: begin
				gap_q <= alu_rsp.res;
			end
			S_FNB: begin
				work_q <= alu_rsp.res;
			end
			S_CLMIN: begin
				if (alu_rsp.cout) begin
					work_q <= min_x;
				end
			end
			S_CLMAX: begin
				if (alu_rsp.cout) begin
					work_q <= max_x;
				end
			end
			S_CHG: begin
				res_q.base_after   <= work_q[DLY_W-1:0];
				res_q.base_changed <= !alu_rsp.zero;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/adaptive_retry_backoff_table.sv
// ----------------------------------------------------------------------------
// adaptive_retry_backoff_table
// Learns one base retry delay per (category, chain) key and answers backoff
// queries and outcome observations against a small associative table.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  req_item (rsp for each)
//   rsp       out        rsp_valid / rsp_ready  rsp_item
//   cfg       in         cfg_we (no stall)      cfg_index, cfg_data
//
// - one transaction at a time; req_ready is low from acceptance until the
//   result has moved into the output register
// - clear, unknown opcode and no-category transactions skip the table scan
// - a keyed transaction scans the table one entry a cycle through the RAM
//   read port, ending early on a hit
// - query then doubles the base once per retry (at most 31 times) while it
//   stays nonzero and below max; observe forms a target directly for zero
//   retries, else by compare and growth steps (at most 31), then steps toward
//   it, clamps and writes back, all on the shared adder
// - reset (arst_n, async) empties the table through its valid bits at once
// - a result waiting on rsp_ready does not stop the next transaction from
//   being accepted; only a second finished result waits for the register
//
`default_nettype none

module adaptive_retry_backoff_table (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [arbt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [arbt_pkg::DLY_W-1:0]           cfg_data,
	input  wire logic                                 req_valid,
	output      logic                                 req_ready,
	input  wire arbt_pkg::req_item_t                  req_item,
	output      logic                                 rsp_valid,
	input  wire logic                                 rsp_ready,
	output      arbt_pkg::rsp_item_t                  rsp_item
);
	import arbt_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// sequencer result handoff
	logic      res_valid;
	logic      res_ready;
	rsp_item_t res_item;

	// output register
	logic      rsp_vld_q;
	rsp_item_t rsp_item_q;

	// table RAM ports
	tbl_wr_t tbl_wr;
	tbl_rd_t tbl_rd;
	entry_t  tbl_rdata;

	// plain register writes; the user must do them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_delay     <= MIN_DELAY_RST;
			cfg_q.max_delay     <= MAX_DELAY_RST;
			cfg_q.default_delay <= DEFAULT_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_DELAY:     cfg_q.min_delay     <= cfg_data;
				REG_MAX_DELAY:     cfg_q.max_delay     <= cfg_data;
				REG_DEFAULT_DELAY: cfg_q.default_delay <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// sequencer with shared add / subtract unit
	arbt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.tbl_wr    (tbl_wr),
		.tbl_rd    (tbl_rd),
		.tbl_rdata (tbl_rdata)
	);

	// key and base store; valid bits live in the sequencer
	arbt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_wr.en),
		.waddr (tbl_wr.addr),
		.wdata (tbl_wr.data),
		.re    (tbl_rd.en),
		.raddr (tbl_rd.addr),
		.rdata (tbl_rdata)
	);

	// output register takes a new result when empty or being drained
	assign res_ready = !rsp_vld_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_item_q <= res_item;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_item  = rsp_item_q;

endmodule

`default_nettype wire

>>> src/arbt_checker.sv
// ----------------------------------------------------------------------------
// arbt_checker
// Port-level checks for the backoff table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arbt_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           req_valid,
	input wire logic                           req_ready,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_ready,
	input wire arbt_pkg::rsp_item_t            rsp_item
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
		else $error("rsp transaction changed while stalled");

	// one transaction in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req accepted while previous transaction in work");

	// only an observe changes the base, and an observe returns no delay
	a_changed_no_delay: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.base_changed |-> rsp_item.delay_ms == '0)
		else $error("changed base reported together with a delay");

	// nothing offered after a reset edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("rsp_valid high after reset");

endmodule

bind adaptive_retry_backoff_table arbt_checker u_arbt_checker (.*);

`default_nettype wire

>>> sim/arbt_delay_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arbt_delay_checker
// Watches the request, result and register ports of the backoff table, keeps
// its own copy of the learned delays and compares every result in order.
// ----------------------------------------------------------------------------

module arbt_delay_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [arbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arbt_pkg::DLY_W-1:0]     cfg_data,
	input  logic                           req_valid,
	input  logic                           req_ready,
	input  arbt_pkg::req_item_t            req_item,
	input  logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  arbt_pkg::rsp_item_t            rsp_item,
	output int                             fail_count,
	output int                             results_due,
	output int                             answers_seen
);

	import arbt_pkg::*;

	// register copies
	logic [DLY_W-1:0] lim_min;
	logic [DLY_W-1:0] lim_max;
	logic [DLY_W-1:0] lim_default;

	// learned delay table
	logic             slot_used  [TABLE_ENTRIES];
	logic [CAT_W-1:0] slot_cat   [TABLE_ENTRIES];
	logic [63:0]      slot_chain [TABLE_ENTRIES];
	logic [31:0]      slot_base  [TABLE_ENTRIES];

	rsp_item_t answers_due[$];
	rsp_item_t want;
	int        bad;
	int        seen;

	function automatic void clear_slots();
		int i;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			slot_used[i]  = 1'b0;
			slot_cat[i]   = '0;
			slot_chain[i] = '0;
			slot_base[i]  = '0;
		end
	endfunction

	// key match over used slots, else first free slot, else slot 0
	function automatic int find_slot(input logic [CAT_W-1:0] cat, input logic [63:0] chain);
		int i;
		int hit;
		int slot;
		bit have_free;
		hit = -1;
		slot = 0;
		have_free = 1'b0;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			if (!slot_used[i]) begin
				if (!have_free) begin
					slot = i;
					have_free = 1'b1;
				end
			end else if (hit < 0 && slot_chain[i] == chain && slot_cat[i] == cat) begin
				hit = i;
			end
		end
		if (hit >= 0)
			return hit;
		slot_used[slot]  = 1'b1;
		slot_cat[slot]   = cat;
		slot_chain[slot] = chain;
		slot_base[slot]  = {1'b0, lim_default};
		return slot;
	endfunction

	function automatic rsp_item_t compute_backoff(input req_item_t it);
		rsp_item_t r;
		int e;
		int i;
		bit stop;
		longint unsigned base, d, target, mult, cur, nb;
		r = '0;
		case (it.opcode)
			OP_QUERY: begin
				if (!it.has_category) begin
					r.delay_ms = lim_default;
				end else begin
					e = find_slot(it.category_id[CAT_W-1:0], it.chain_id);
					base = 64'(slot_base[e]);
					d = base;
					for (i = 0; i < it.retry_num && d < lim_max && d != 0; i++)
						d = d << 1;
					r.delay_ms = (d > lim_max) ? lim_max : d[DLY_W-1:0];
					r.base_after = base[DLY_W-1:0];
				end
			end
			OP_OBSERVE: begin
				if (it.has_category) begin
					e = find_slot(it.category_id[CAT_W-1:0], it.chain_id);
					base = 64'(slot_base[e]);
					if (it.retry_num == 0) begin
						target = (base * 3) / 4;
					end else begin
						// 2^R - 1, growth stops once past the ceiling
						mult = 0;
						cur = 1;
						stop = 1'b0;
						for (i = 0; i < it.retry_num && !stop; i++) begin
							mult += cur;
							if (cur > lim_max)
								stop = 1'b1;
							else
								cur = cur << 1;
						end
						target = mult * base;
						if (target > lim_max)
							target = 64'(lim_max);
					end
					// fast rise, slow fall
					if (target > base)
						nb = base + ((target - base + 1) >> 1);
					else if (target < base)
						nb = base - ((base - target + 7) >> 3);
					else
						nb = base;
					if (nb < lim_min)
						nb = 64'(lim_min);
					else if (nb > lim_max)
						nb = 64'(lim_max);
					if (nb != base) begin
						slot_base[e] = nb[31:0];
						r.base_changed = 1'b1;
					end
					r.base_after = slot_base[e][DLY_W-1:0];
				end
			end
			OP_CLEAR: clear_slots();
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_field(input string what, input longint unsigned exp_v,
		input longint unsigned got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, got_v);
			bad++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_min     = MIN_DELAY_RST;
			lim_max     = MAX_DELAY_RST;
			lim_default = DEFAULT_DELAY_RST;
			clear_slots();
			answers_due.delete();
			bad = 0;
			seen = 0;
			fail_count   <= 0;
			results_due  <= 0;
			answers_seen <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				seen++;
				if (answers_due.size() == 0) begin
					$display("%0t: result with nothing expected, actual %0d/%0d/%0d", $time,
						rsp_item.delay_ms, rsp_item.base_after, rsp_item.base_changed);
					bad++;
				end else begin
					want = answers_due.pop_front();
					report_field("delay_ms", want.delay_ms, rsp_item.delay_ms);
					report_field("base_after", want.base_after, rsp_item.base_after);
					report_field("base_changed", want.base_changed, rsp_item.base_changed);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_DELAY:     lim_min = cfg_data;
					REG_MAX_DELAY:     lim_max = cfg_data;
					REG_DEFAULT_DELAY: lim_default = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				answers_due.push_back(compute_backoff(req_item));
			fail_count   <= bad;
			results_due  <= answers_due.size();
			answers_seen <= seen;
		end
	end

endmodule

>>> sim/tb_adaptive_retry_backoff_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_retry_backoff_table
// Drives queries, observes and clears into the backoff table under several
// register settings, with random sender bursts and receiver stalls; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_adaptive_retry_backoff_table;

	import arbt_pkg::*;

	// opcode and register index the package leaves unnamed
	localparam logic [OPC_W-1:0]     OP_NOP     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int ITEMS_PER_PHASE = 120;
	localparam int NUM_PHASES      = 7;
	localparam int KEY_POOL        = 12;
	// longest correct stretch without a transaction stays well under this limit
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int END_WAIT        = 100;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DLY_W-1:0]     cfg_data  = '0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_item_t            req_item  = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_item_t            rsp_item;

	int fail_count;
	int results_due;
	int answers_seen;

	// key pool, so that lookups hit, miss and overflow the table
	logic [7:0]  pool_cat   [KEY_POOL];
	logic [63:0] pool_chain [KEY_POOL];

	// sender pacing
	bit idle_on;
	int burst_left;

	// transaction tallies for the closing summary
	int n_query;
	int n_observe;
	int n_clear;
	int n_other;
	int n_settings;

	// receiver stall pattern
	logic [15:0] stall_pat = '1;
	int          stall_cnt = 0;

	int quiet = 0;

	adaptive_retry_backoff_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item)
	);

	arbt_delay_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_item     (req_item),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp_item     (rsp_item),
		.fail_count   (fail_count),
		.results_due  (results_due),
		.answers_seen (answers_seen)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: a 16-bit stall pattern, rotated and reloaded at random when stall_cnt wraps
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (stall_cnt == 15) begin
				stall_cnt <= 0;
				case ($urandom_range(0, 3))
					0: stall_pat <= '1;              // stretch with no stalls
					1: stall_pat <= 16'hf000;        // long stall
					default: stall_pat <= 16'($urandom);
				endcase
			end else begin
				stall_cnt <= stall_cnt + 1;
				stall_pat <= {stall_pat[0], stall_pat[15:1]};
			end
			rsp_ready <= stall_pat[0];
		end
	end

	// watchdog: too long without any transaction ends the run
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic req_item_t mk_item(input logic [OPC_W-1:0] op, input logic has_cat,
		input logic [7:0] cat, input logic [63:0] chain, input logic [15:0] retries);
		req_item_t it;
		it.opcode       = op;
		it.has_category = has_cat;
		it.category_id  = cat;
		it.chain_id     = chain;
		it.retry_num    = retries;
		return it;
	endfunction

	function automatic req_item_t random_item();
		req_item_t it;
		int pick;
		int k;
		k = $urandom_range(0, KEY_POOL - 1);
		it.has_category = 1'b1;
		it.category_id  = pool_cat[k];
		it.chain_id     = pool_chain[k];
		// mostly pool keys, some near misses and fresh keys
		pick = $urandom_range(0, 99);
		if (pick < 8)
			it.category_id = 8'($urandom);
		else if (pick < 16)
			it.chain_id = it.chain_id ^ (64'd1 << $urandom_range(0, 63));
		else if (pick < 22)
			it.chain_id = {$urandom, $urandom};
		// retries: mostly small, some reaching saturation, a few anywhere
		pick = $urandom_range(0, 99);
		if (pick < 60)
			it.retry_num = 16'($urandom_range(0, 3));
		else if (pick < 85)
			it.retry_num = 16'($urandom_range(0, 33));
		else
			it.retry_num = 16'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			it.opcode = OP_QUERY;
		end else if (pick < 88) begin
			it.opcode = OP_OBSERVE;
		end else if (pick < 92) begin
			it.opcode = OP_CLEAR;
		end else if (pick < 98) begin
			// no category, key content is noise
			it.opcode       = ($urandom_range(0, 1) != 0) ? OP_QUERY : OP_OBSERVE;
			it.has_category = 1'b0;
			it.category_id  = 8'($urandom);
			it.chain_id     = {$urandom, $urandom};
		end else begin
			it.opcode = OP_NOP;
		end
		return it;
	endfunction

	// hold the transaction until accepted, then maybe open a gap
	task automatic push_item(input req_item_t it);
		req_item  <= it;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		case (it.opcode)
			OP_QUERY:   n_query++;
			OP_OBSERVE: n_observe++;
			OP_CLEAR:   n_clear++;
			default:    n_other++;
		endcase
		if (burst_left > 0)
			burst_left--;
		if (idle_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// sender pauses until every outstanding result has come back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
	endtask

	// write all registers back to back; block must be idle
	task automatic set_config(input logic [DLY_W-1:0] lo, input logic [DLY_W-1:0] hi,
		input logic [DLY_W-1:0] dflt);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_DELAY;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_MAX_DELAY;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= REG_DEFAULT_DELAY;
		cfg_data  <= dflt;
		@(posedge clk);
		// unmapped index, must be ignored
		cfg_index <= REG_UNUSED;
		cfg_data  <= DLY_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	initial begin
		int ph;
		int n;
		int k;
		n_query    = 0;
		n_observe  = 0;
		n_clear    = 0;
		n_other    = 0;
		n_settings = 1;
		idle_on    = 1'b1;
		burst_left = 4;

		// extreme keys first, the rest random
		pool_cat[0] = 8'h00; pool_chain[0] = '0;
		pool_cat[1] = 8'hff; pool_chain[1] = '1;
		pool_cat[2] = 8'h00; pool_chain[2] = '1;
		pool_cat[3] = 8'hff; pool_chain[3] = '0;
		for (k = 4; k < KEY_POOL; k++) begin
			pool_cat[k]   = 8'($urandom);
			pool_chain[k] = {$urandom, $urandom};
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset register values
		push_item(mk_item(OP_QUERY, 1'b0, 8'hff, '1, 16'hffff));  // no category query
		push_item(mk_item(OP_OBSERVE, 1'b0, 8'hff, '1, 16'hffff)); // no category observe
		push_item(mk_item(OP_NOP, 1'b1, 8'h00, '0, 16'h0000));     // unused opcode
		push_item(mk_item(OP_QUERY, 1'b1, 8'h00, '0, 16'd0));      // allocate at default
		push_item(mk_item(OP_QUERY, 1'b1, 8'h00, '0, 16'd3));      // plain doubling
		push_item(mk_item(OP_QUERY, 1'b1, 8'h00, '0, 16'hffff));   // saturates at max
		push_item(mk_item(OP_OBSERVE, 1'b1, 8'h00, '0, 16'd0));    // falling step
		push_item(mk_item(OP_OBSERVE, 1'b1, 8'h00, '0, 16'd1));    // target equals base
		push_item(mk_item(OP_OBSERVE, 1'b1, 8'h00, '0, 16'd2));    // rising step
		push_item(mk_item(OP_OBSERVE, 1'b1, 8'h00, '0, 16'hffff)); // target saturates
		push_item(mk_item(OP_OBSERVE, 1'b1, 8'hff, '1, 16'hffff));
		push_item(mk_item(OP_QUERY, 1'b1, 8'h00, '1, 16'd1));      // chain match only
		push_item(mk_item(OP_QUERY, 1'b1, 8'hff, '0, 16'd1));      // category match only
		// fill the table, the last one evicts slot 0
		for (k = 1; k <= 5; k++)
			push_item(mk_item(OP_OBSERVE, 1'b1, k[7:0], 64'd1 << (k * 11), 16'd0));
		push_item(mk_item(OP_QUERY, 1'b1, 8'h00, '0, 16'd2));      // evicted key comes back
		push_item(mk_item(OP_CLEAR, 1'b1, 8'hff, '1, 16'hffff));
		push_item(mk_item(OP_QUERY, 1'b1, 8'hff, '1, 16'd4));      // fresh after clear
		drain();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				1: set_config('0, '1, 31'd1);
				2: set_config('1, 31'd1, '1);          // min above max, min wins
				3: set_config('0, 31'd1, '0);          // zero bases stay zero
				4: set_config(31'd50, 31'd100000, 31'd300);
				5: set_config(DLY_W'($urandom_range(0, 1000)),
					DLY_W'($urandom_range(1000, 2000000)),
					DLY_W'($urandom_range(0, 3000000)));
				6: set_config(MIN_DELAY_RST, MAX_DELAY_RST, DEFAULT_DELAY_RST);
				default: ;
			endcase
			// freshen part of the key pool
			for (k = 4; k < KEY_POOL; k++) begin
				if ($urandom_range(0, 2) == 0) begin
					pool_cat[k]   = 8'($urandom);
					pool_chain[k] = {$urandom, $urandom};
				end
			end
			// some phases run with the sender never idling
			idle_on = (ph != 1 && ph != 5);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				push_item(random_item());
				if (ph == 4 && n == ITEMS_PER_PHASE / 2)
					drain();
			end
			drain();
		end

		repeat (END_WAIT) @(posedge clk);

		$display("sent %0d transactions: %0d query, %0d observe, %0d clear, %0d other",
			n_query + n_observe + n_clear + n_other, n_query, n_observe, n_clear, n_other);
		$display("%0d results compared across %0d register settings", answers_seen,
			n_settings);
		if (fail_count == 0 && results_due == 0) begin
			$display("TB_OK");
		end else begin
			$display("failures %0d, results still expected %0d", fail_count, results_due);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
